>>> sv/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic clocked assertion, disabled while the active-low reset is low.
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assertion on the block clock and reset.
`define ASSERT_SYNC(lbl, prop, msg) `ASSERT_RST(lbl, i_clk, i_rst_n, prop, msg)

`endif

>>> sv/pdc_pkg.sv
// Package: widths, constants and state types of the PWM duty capture block.
package pdc_pkg;

    localparam int FRAC_BITS = 16;

    localparam int TIME_W   = 63;
    localparam int PERIOD_W = 32;
    localparam int DUTY_W   = 17;
    localparam int SCALE_W  = 8;
    localparam int OFFS_W   = 17;
    localparam int CFG_W    = 17;
    localparam int HIGH_W   = 49;
    localparam int SH_W     = SCALE_W + HIGH_W;

    // quotient bits needed before the result is known to clamp to one
    localparam int QUO_W    = ((FRAC_BITS > OFFS_W) ? FRAC_BITS : OFFS_W) + 1;
    localparam int SAT_SH   = QUO_W - FRAC_BITS;
    localparam int CNT_W    = $clog2(QUO_W);

    localparam logic [HIGH_W-1:0]   HIGH_CAP     = HIGH_W'(1) << (HIGH_W - 1);
    localparam logic [QUO_W-1:0]    ONE_Q        = QUO_W'(1) << FRAC_BITS;
    localparam logic [SCALE_W-1:0]  SCALE_RST    = SCALE_W'(20);
    localparam logic [OFFS_W-1:0]   OFFSET_RST   = OFFS_W'(65536);
    localparam logic [DUTY_W-1:0]   DUTY_RST     = DUTY_W'(65536);
    localparam logic [PERIOD_W-1:0] PERIOD_RST   = PERIOD_W'(1);

    typedef enum logic [0:0] {
        CFG_SCALE  = 1'b0,
        CFG_OFFSET = 1'b1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_FIN
    } t_state;

    typedef enum logic [1:0] {
        DV_IDLE,
        DV_CHK,
        DV_RUN
    } t_div_state;

    typedef struct packed {
        logic             done;
        logic             sat;
        logic [QUO_W-1:0] quo;
    } t_div_res;

endpackage

>>> sv/pdc_chan_if.sv
// Request channel interfaces: edge events in, duty/period reports out.
interface pdc_in_if;
    logic                       valid;
    logic                       ready;
    logic                       pin_level;
    logic [pdc_pkg::TIME_W-1:0] time_us;

    modport source (output valid, output pin_level, output time_us, input ready);
    modport sink   (input valid, input pin_level, input time_us, output ready);
endinterface

interface pdc_out_if;
    logic                         valid;
    logic                         ready;
    logic [pdc_pkg::DUTY_W-1:0]   duty_q16;
    logic [pdc_pkg::PERIOD_W-1:0] period_us;
    logic                         duty_updated;

    modport source (output valid, output duty_q16, output period_us,
                    output duty_updated, input ready);
    modport sink   (input valid, input duty_q16, input period_us,
                    input duty_updated, output ready);
endinterface

>>> sv/pdc_div.sv
// Iterative restoring divider: saturation check, then one quotient bit per cycle.
module pdc_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [pdc_pkg::SH_W-1:0]     i_sh,
    input  logic [pdc_pkg::PERIOD_W-1:0] i_period,
    output pdc_pkg::t_div_res            o_res
);

    pdc_pkg::t_div_state r_state, n_state;

    logic [pdc_pkg::SH_W-1:0]     r_sh;
    logic [pdc_pkg::PERIOD_W-1:0] r_p;
    logic [pdc_pkg::PERIOD_W-1:0] r_rem;
    logic [pdc_pkg::QUO_W-1:0]    r_x;
    logic [pdc_pkg::QUO_W-1:0]    r_q;
    logic [pdc_pkg::CNT_W-1:0]    r_cnt;
    logic                         r_sat;
    logic                         r_done;

    logic                         w_load, w_chk, w_run;
    logic                         w_sat, w_last, w_ge;
    logic [pdc_pkg::SH_W-1:0]     w_p_sh;
    logic [pdc_pkg::PERIOD_W:0]   w_trial;
    logic [pdc_pkg::PERIOD_W:0]   w_diff;

    assign w_p_sh  = pdc_pkg::SH_W'({r_p, {pdc_pkg::SAT_SH{1'b0}}});
    assign w_sat   = (r_sh >= w_p_sh);
    assign w_last  = (r_cnt == pdc_pkg::CNT_W'(pdc_pkg::QUO_W - 1));
    assign w_trial = {r_rem, r_x[pdc_pkg::QUO_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_p});
    assign w_diff  = w_trial - {1'b0, r_p};

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pdc_pkg::DV_IDLE: if (i_start) n_state = pdc_pkg::DV_CHK;
            pdc_pkg::DV_CHK:  n_state = w_sat ? pdc_pkg::DV_IDLE : pdc_pkg::DV_RUN;
            pdc_pkg::DV_RUN:  if (w_last) n_state = pdc_pkg::DV_IDLE;
            default:          n_state = pdc_pkg::DV_IDLE;
        endcase
    end

    always_comb begin
        w_load = 1'b0;
        w_chk  = 1'b0;
        w_run  = 1'b0;
        unique case (r_state)
            pdc_pkg::DV_IDLE: w_load = i_start;
            pdc_pkg::DV_CHK:  w_chk  = 1'b1;
            pdc_pkg::DV_RUN:  w_run  = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pdc_pkg::DV_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (w_chk && w_sat) || (w_run && w_last);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_sh <= i_sh;
            r_p  <= i_period;
        end
        if (w_chk) begin
            r_sat <= w_sat;
            r_rem <= pdc_pkg::PERIOD_W'(r_sh >> pdc_pkg::SAT_SH);
            r_x   <= {r_sh[pdc_pkg::SAT_SH-1:0], {pdc_pkg::FRAC_BITS{1'b0}}};
            r_cnt <= '0;
        end
        if (w_run) begin
            r_rem <= w_ge ? w_diff[pdc_pkg::PERIOD_W-1:0] : w_trial[pdc_pkg::PERIOD_W-1:0];
            r_q   <= {r_q[pdc_pkg::QUO_W-2:0], w_ge};
            r_x   <= r_x << 1;
            r_cnt <= r_cnt + pdc_pkg::CNT_W'(1);
        end
    end

    assign o_res.done = r_done;
    assign o_res.sat  = r_sat;
    assign o_res.quo  = r_q;

endmodule

>>> sv/pwm_pulse_duty_capture.sv
// Top level: PWM edge capture, period latch and duty computation sequencer.
// Rising edge or zero period: the result is registered in the cycle after the request.
// Falling edge: Q1.16 duty via states MUL, DIV and FIN, set by the restoring divider that
// produces one quotient bit per cycle (quotient width 18); saturation skips the bit loop.
// One request at a time; a new request is taken once the previous result can leave.
// Reset (synchronous, active low): period 1, last rise 0, duty 1.0, scale 20,
// offset 1.0, output empty.
module pwm_pulse_duty_capture (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  pdc_pkg::t_cfg_idx         i_cfg_idx,
    input  logic [pdc_pkg::CFG_W-1:0] i_cfg_data,
    pdc_in_if.sink                    i_in,
    pdc_out_if.source                 o_out
);

    `include "assert_macros.svh"

    pdc_pkg::t_state r_state, n_state;

    logic [pdc_pkg::SCALE_W-1:0]  r_scale;
    logic [pdc_pkg::OFFS_W-1:0]   r_offset;
    logic [pdc_pkg::PERIOD_W-1:0] r_period;
    logic [pdc_pkg::TIME_W-1:0]   r_last_rise;
    logic [pdc_pkg::DUTY_W-1:0]   r_duty;
    logic [pdc_pkg::HIGH_W-1:0]   r_high;

    logic                         r_out_valid;
    logic [pdc_pkg::DUTY_W-1:0]   r_out_duty;
    logic [pdc_pkg::PERIOD_W-1:0] r_out_period;
    logic                         r_out_upd;

    logic                         w_slot, w_acc, w_rise, w_calc;
    logic                         w_in_ready, w_start, w_fin_load;
    logic [pdc_pkg::TIME_W-1:0]   w_delta;
    logic [pdc_pkg::PERIOD_W-1:0] w_period_new;
    logic [pdc_pkg::HIGH_W-1:0]   w_high_new;
    logic [pdc_pkg::SH_W-1:0]     w_sh;
    logic [pdc_pkg::QUO_W-1:0]    w_off, w_sub, w_val;
    pdc_pkg::t_div_res            w_div;

    assign w_slot  = !r_out_valid || o_out.ready;
    assign w_acc   = i_in.valid && w_in_ready;
    assign w_rise  = i_in.pin_level;
    assign w_calc  = w_acc && !w_rise && (r_period != '0);
    assign w_delta = i_in.time_us - r_last_rise;

    assign w_period_new = (|w_delta[pdc_pkg::TIME_W-1:pdc_pkg::PERIOD_W]) ? '1
                        : w_delta[pdc_pkg::PERIOD_W-1:0];
    assign w_high_new   = (w_delta > pdc_pkg::TIME_W'(pdc_pkg::HIGH_CAP)) ? pdc_pkg::HIGH_CAP
                        : w_delta[pdc_pkg::HIGH_W-1:0];

    assign w_sh = pdc_pkg::SH_W'(r_scale) * pdc_pkg::SH_W'(r_high);

    pdc_div u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_start),
        .i_sh     (w_sh),
        .i_period (r_period),
        .o_res    (w_div)
    );

    // offset subtract and clamp to 0..1
    assign w_off = pdc_pkg::QUO_W'(r_offset);
    assign w_sub = w_div.quo - w_off;
    always_comb begin
        if (w_div.sat) begin
            w_val = pdc_pkg::ONE_Q;
        end else if (w_div.quo <= w_off) begin
            w_val = '0;
        end else if (w_sub > pdc_pkg::ONE_Q) begin
            w_val = pdc_pkg::ONE_Q;
        end else begin
            w_val = w_sub;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pdc_pkg::ST_IDLE: if (w_calc) n_state = pdc_pkg::ST_MUL;
            pdc_pkg::ST_MUL:  n_state = pdc_pkg::ST_DIV;
            pdc_pkg::ST_DIV:  if (w_div.done) n_state = pdc_pkg::ST_FIN;
            pdc_pkg::ST_FIN:  if (w_slot) n_state = pdc_pkg::ST_IDLE;
            default:          n_state = pdc_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        w_in_ready = 1'b0;
        w_start    = 1'b0;
        w_fin_load = 1'b0;
        unique case (r_state)
            pdc_pkg::ST_IDLE: w_in_ready = w_slot;
            pdc_pkg::ST_MUL:  w_start    = 1'b1;
            pdc_pkg::ST_DIV:  ;
            pdc_pkg::ST_FIN:  w_fin_load = w_slot;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pdc_pkg::ST_IDLE;
            r_scale     <= pdc_pkg::SCALE_RST;
            r_offset    <= pdc_pkg::OFFSET_RST;
            r_period    <= pdc_pkg::PERIOD_RST;
            r_last_rise <= '0;
            r_duty      <= pdc_pkg::DUTY_RST;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    pdc_pkg::CFG_SCALE:  r_scale  <= i_cfg_data[pdc_pkg::SCALE_W-1:0];
                    pdc_pkg::CFG_OFFSET: r_offset <= i_cfg_data[pdc_pkg::OFFS_W-1:0];
                    default: ;
                endcase
            end
            if (w_acc && w_rise) begin
                r_period    <= w_period_new;
                r_last_rise <= i_in.time_us;
            end
            if (r_state == pdc_pkg::ST_DIV && w_div.done) begin
                r_duty <= pdc_pkg::DUTY_W'(w_val);
            end
            if ((w_acc && !w_calc) || w_fin_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_calc) begin
            r_high <= w_high_new;
        end
        if (w_acc && !w_calc) begin
            r_out_duty   <= r_duty;
            r_out_period <= w_rise ? w_period_new : r_period;
            r_out_upd    <= 1'b0;
        end else if (w_fin_load) begin
            r_out_duty   <= r_duty;
            r_out_period <= r_period;
            r_out_upd    <= 1'b1;
        end
    end

    assign i_in.ready         = w_in_ready;
    assign o_out.valid        = r_out_valid;
    assign o_out.duty_q16     = r_out_duty;
    assign o_out.period_us    = r_out_period;
    assign o_out.duty_updated = r_out_upd;

    `ASSERT_SYNC(a_done_in_div, w_div.done |-> (r_state == pdc_pkg::ST_DIV), "divider done outside wait")
    `ASSERT_SYNC(a_calc_starts, w_calc |=> (r_state == pdc_pkg::ST_MUL), "falling edge did not start")
    `ASSERT_SYNC(a_fin_reports, w_fin_load |=> (o_out.valid && o_out.duty_updated), "duty not reported")
    `ASSERT_SYNC(a_busy_no_req, (r_state != pdc_pkg::ST_IDLE) |-> !i_in.ready, "request taken while busy")

endmodule

>>> sim/testbench.sv
// Testbench for the PWM duty capture block: directed and random edge events with a local predictor.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic [pdc_pkg::DUTY_W-1:0]   duty;
        logic [pdc_pkg::PERIOD_W-1:0] period;
        logic                         updated;
    } t_report;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      cfg_we = 1'b0;
    pdc_pkg::t_cfg_idx         cfg_idx = pdc_pkg::CFG_SCALE;
    logic [pdc_pkg::CFG_W-1:0] cfg_data = '0;

    pdc_in_if  in_if ();
    pdc_out_if out_if ();

    pwm_pulse_duty_capture i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (in_if),
        .o_out      (out_if)
    );

    // predictor state
    logic [pdc_pkg::SCALE_W-1:0]  cap_scale;
    logic [pdc_pkg::OFFS_W-1:0]   cap_offset;
    logic [pdc_pkg::PERIOD_W-1:0] cap_period;
    logic [pdc_pkg::TIME_W-1:0]   cap_last_rise;
    logic [pdc_pkg::DUTY_W-1:0]   cap_duty;

    t_report expected_reports[$];
    int      n_err = 0;
    int      n_items = 0;
    int      n_cycles = 0;
    bit      steady = 1'b0;

    always #1 i_clk = ~i_clk;

    initial begin
        in_if.valid     = 1'b0;
        in_if.pin_level = 1'b0;
        in_if.time_us   = '0;
        out_if.ready    = 1'b0;
    end

    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("%0t timeout, %0d reports outstanding", $realtime, expected_reports.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    always @(negedge i_clk)
        out_if.ready = steady || ($urandom_range(0, 99) >= 31);

    function automatic logic [pdc_pkg::DUTY_W-1:0] capture_duty(
            logic [pdc_pkg::TIME_W-1:0] high_in, logic [pdc_pkg::PERIOD_W-1:0] per);
        logic [63:0] high, sh, qint, rem, frac, ratio, one_q, per64;
        one_q = 64'd1 << pdc_pkg::FRAC_BITS;
        per64 = {32'd0, per};
        high = (high_in > (64'd1 << 48)) ? (64'd1 << 48) : {1'b0, high_in};
        sh = high * {56'd0, cap_scale};
        qint = sh / per64;
        rem = sh % per64;
        if (qint > (64'd1 << 20))
            qint = 64'd1 << 20;
        frac = (rem << pdc_pkg::FRAC_BITS) / per64;
        ratio = (qint << pdc_pkg::FRAC_BITS) + frac;
        if (ratio <= {47'd0, cap_offset})
            return '0;
        ratio = ratio - {47'd0, cap_offset};
        if (ratio > one_q)
            ratio = one_q;
        return ratio[pdc_pkg::DUTY_W-1:0];
    endfunction

    function automatic t_report predict_report(logic lvl, logic [pdc_pkg::TIME_W-1:0] t);
        logic [pdc_pkg::TIME_W-1:0] delta;
        t_report r;
        delta = t - cap_last_rise;
        r.updated = 1'b0;
        if (lvl) begin
            cap_period = (delta > 63'h0_FFFF_FFFF) ? '1 : delta[pdc_pkg::PERIOD_W-1:0];
            cap_last_rise = t;
        end else if (cap_period != '0) begin
            cap_duty = capture_duty(delta, cap_period);
            r.updated = 1'b1;
        end
        r.duty = cap_duty;
        r.period = cap_period;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_report exp_r;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (expected_reports.size() == 0) begin
                $display("%0t unexpected report: expected none, actual duty %0d period %0d upd %0b",
                         $realtime, out_if.duty_q16, out_if.period_us, out_if.duty_updated);
                n_err++;
            end else begin
                exp_r = expected_reports.pop_front();
                if (out_if.duty_q16 !== exp_r.duty) begin
                    $display("%0t duty_q16 mismatch: expected %0d actual %0d",
                             $realtime, exp_r.duty, out_if.duty_q16);
                    n_err++;
                end
                if (out_if.period_us !== exp_r.period) begin
                    $display("%0t period_us mismatch: expected %0d actual %0d",
                             $realtime, exp_r.period, out_if.period_us);
                    n_err++;
                end
                if (out_if.duty_updated !== exp_r.updated) begin
                    $display("%0t duty_updated mismatch: expected %0b actual %0b",
                             $realtime, exp_r.updated, out_if.duty_updated);
                    n_err++;
                end
            end
        end
    end

    // called at a falling edge, returns at a falling edge
    task automatic send_edge(input logic lvl, input logic [pdc_pkg::TIME_W-1:0] t);
        while (!steady && ($urandom_range(0, 99) < 31)) begin
            in_if.valid = 1'b0;
            @(negedge i_clk);
        end
        in_if.valid     = 1'b1;
        in_if.pin_level = lvl;
        in_if.time_us   = t;
        do
            @(posedge i_clk);
        while (!in_if.ready);
        expected_reports.push_back(predict_report(lvl, t));
        n_items++;
        @(negedge i_clk);
    endtask

    task automatic drain;
        in_if.valid = 1'b0;
        while (expected_reports.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_cfg(input pdc_pkg::t_cfg_idx idx,
                             input logic [pdc_pkg::CFG_W-1:0] data);
        drain();
        cfg_we   = 1'b1;
        cfg_idx  = idx;
        cfg_data = data;
        @(negedge i_clk);
        cfg_we = 1'b0;
        if (idx == pdc_pkg::CFG_SCALE)
            cap_scale = data[pdc_pkg::SCALE_W-1:0];
        else
            cap_offset = data[pdc_pkg::OFFS_W-1:0];
    endtask

    task automatic set_cfg(input int sc, input int offs);
        logic [pdc_pkg::CFG_W-1:0] d;
        d = pdc_pkg::CFG_W'(sc);
        d[pdc_pkg::CFG_W-1:pdc_pkg::SCALE_W] = (pdc_pkg::CFG_W - pdc_pkg::SCALE_W)'($urandom);
        write_cfg(pdc_pkg::CFG_SCALE, d);
        write_cfg(pdc_pkg::CFG_OFFSET, pdc_pkg::CFG_W'(offs));
    endtask

    task automatic test_reset_defaults;
        send_edge(1'b0, 63'd3);
        send_edge(1'b1, 63'd10);
        send_edge(1'b0, 63'd10);
    endtask

    task automatic test_duty_basic;
        set_cfg(1, 0);
        send_edge(1'b1, 63'd1000);
        send_edge(1'b1, 63'd2000);
        send_edge(1'b0, 63'd2250);
        send_edge(1'b0, 63'd2000);
    endtask

    task automatic test_zero_period;
        send_edge(1'b1, 63'd5000);
        send_edge(1'b1, 63'd5000);
        send_edge(1'b0, 63'd5100);
        send_edge(1'b1, 63'd6000);
    endtask

    task automatic test_time_wrap;
        set_cfg(20, 65536);
        send_edge(1'b1, '1);
        send_edge(1'b0, 63'd0);
        send_edge(1'b1, 63'd50);
        send_edge(1'b1, 63'd10);
        send_edge(1'b0, 63'd5);
    endtask

    task automatic test_scale_extremes;
        set_cfg(0, 0);
        send_edge(1'b1, 63'd20000);
        send_edge(1'b0, 63'd20300);
        set_cfg(255, 0);
        send_edge(1'b1, 63'd120000);
        send_edge(1'b0, 63'd120010);
        send_edge(1'b0, 63'h7FFF_FFFF_0000_0000);
    endtask

    task automatic test_offset_extremes;
        set_cfg(255, 131071);
        send_edge(1'b1, 63'd220000);
        send_edge(1'b0, 63'd221000);
        set_cfg(255, 65536);
        send_edge(1'b0, 63'd220500);
        set_cfg(1, 0);
        send_edge(1'b0, 63'd320000);
        send_edge(1'b0, 63'd330000);
    endtask

    task automatic test_random_pwm;
        logic [pdc_pkg::TIME_W-1:0] now_t, high;
        logic [63:0] tmp, per, sc, u;
        int target, r, p;
        int scs[8], offs[8], lens[8];
        scs  = '{20, 1, 255, 255, 0, 0, 0, 20};
        offs = '{65536, 0, 0, 131071, 0, 0, 0, 65536};
        lens = '{170, 170, 170, 200, 170, 30, 170, 170};
        tmp = {$urandom, $urandom};
        now_t = tmp[pdc_pkg::TIME_W-1:0];
        for (p = 0; p < 8; p++) begin
            if (p == 4) begin
                scs[p] = $urandom_range(1, 255);
                offs[p] = $urandom_range(0, 65536);
            end
            if (p == 5)
                offs[p] = $urandom_range(0, 131071);
            if (p == 6) begin
                scs[p] = $urandom_range(2, 254);
                offs[p] = $urandom_range(65537, 131071);
            end
            set_cfg(scs[p], offs[p]);
            steady = (p == 3);
            target = n_items + lens[p];
            while (n_items < target) begin
                r = $urandom_range(0, 99);
                if (r < 10) begin
                    tmp = {$urandom, $urandom};
                    send_edge(1'($urandom_range(0, 1)), tmp[pdc_pkg::TIME_W-1:0]);
                end else begin
                    r = $urandom_range(0, 99);
                    if (r < 2)
                        per = 0;
                    else if (r < 80)
                        per = 64'($urandom_range(1, 50000));
                    else if (r < 95)
                        per = {32'd0, $urandom};
                    else
                        per = {30'd0, 2'($urandom_range(1, 3)), $urandom};
                    now_t = now_t + per[pdc_pkg::TIME_W-1:0];
                    send_edge(1'b1, now_t);
                    if ($urandom_range(0, 99) < 95) begin
                        r = $urandom_range(0, 99);
                        sc = (cap_scale == 0) ? 64'd1 : {56'd0, cap_scale};
                        if (r < 70) begin
                            u = 64'($urandom_range(0, int'(cap_offset) + 2 * 65536));
                            tmp = (per * u) / (sc << pdc_pkg::FRAC_BITS);
                        end else if (r < 90) begin
                            tmp = {$urandom, $urandom};
                            tmp = tmp % (per + 1);
                        end else begin
                            tmp = {$urandom, $urandom};
                        end
                        high = tmp[pdc_pkg::TIME_W-1:0];
                        send_edge(1'b0, now_t + high);
                    end
                end
            end
        end
        steady = 1'b0;
    endtask

    initial begin
        cap_scale     = pdc_pkg::SCALE_RST;
        cap_offset    = pdc_pkg::OFFSET_RST;
        cap_period    = pdc_pkg::PERIOD_RST;
        cap_last_rise = '0;
        cap_duty      = pdc_pkg::DUTY_RST;
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_reset_defaults();
        test_duty_basic();
        test_zero_period();
        test_time_wrap();
        test_scale_extremes();
        test_offset_extremes();
        test_random_pwm();

        drain();
        repeat (40) @(negedge i_clk);
        if (n_err == 0 && expected_reports.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule

>>> files.f
+incdir+sv
sv/pdc_pkg.sv
sv/pdc_chan_if.sv
sv/pdc_div.sv
sv/pwm_pulse_duty_capture.sv
sim/testbench.sv
